/* hdl/rwt_pkg.sv */
package rwt_pkg;

  // Window geometry. The slot of a sequence is its low bits, so WINDOW is a power of two.
  localparam int WINDOW    = 64;
  localparam int SLOT_BITS = $clog2(WINDOW);
  localparam int SEQ_BITS  = 16;
  localparam int BMP_BITS  = 64;

  // Field widths on the stream ports.
  localparam int SEQ_FIELD_W = 16;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 88;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OUTSIDE = 2'd0,
    ST_DUP     = 2'd1,
    ST_DELIV   = 2'd2,
    ST_HELD    = 2'd3
  } rwt_status_t;

  // Operations on the per-channel window state.
  typedef enum logic [1:0] {
    OP_NONE    = 2'd0,
    OP_SET     = 2'd1,
    OP_CLR_ADV = 2'd2
  } rwt_op_t;

  // Command from the sequencer to the window state.
  typedef struct packed {
    rwt_op_t              op;
    logic                 ch;
    logic [SLOT_BITS-1:0] slot;
  } rwt_cmd_t;

  // State of the selected channel as seen by the sequencer.
  typedef struct packed {
    logic [SEQ_BITS-1:0] expect_seq;
    logic [BMP_BITS-1:0] bits;
  } rwt_view_t;

endpackage

/* hdl/receive_ack_window_tracker.sv */
// Receive-side acknowledgement window tracker for two channels: channel 0 is
// reliable, channel 1 is ordered. Each header transfer on the slave side gives
// exactly one result transfer carrying the status, the deliver flag and the
// channel's next expected sequence, window bitmap and replay flag after the
// update. The block takes one header at a time: it is evaluated and then waits
// in the done state for the output register. A reliable header that is delivered
// also walks the advance state, clearing each received slot it moves past (up to
// 64), since the next expected sequence moves past the window bitmap one slot per
// cycle through a single shared bit-clear and increment unit. A finished result
// waits in an output register, so the next header is taken while it is pending.
module receive_ack_window_tracker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [rwt_pkg::IN_DATA_W-1:0]   s_tdata,  // [15:0] seq_num
  input  logic [0:0]                      s_tuser,  // [0] chan_sel
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [1:0] status, [2] deliver, [18:3] next_expected, [82:19] ack_bitmap,
  // [83] replay_ready, [87:84] zero
  output logic [rwt_pkg::OUT_DATA_W-1:0]  m_tdata
);
  import rwt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_ADV,
    S_DONE
  } state_t;

  state_t              state;
  logic                ch_r;
  logic [SEQ_BITS-1:0] seq_r;
  rwt_status_t         status_r;
  logic                deliver_r;

  rwt_cmd_t            cmd;
  rwt_view_t           view;
  logic [SEQ_BITS:0]   diff;
  logic                in_win;
  logic                seq_hit;
  logic                exp_hit;
  logic                out_free;

  rwt_state u_state (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .view (view)
  );

  // Window test without wrap-around, and the bitmap probes.
  assign diff     = {1'b0, seq_r} - {1'b0, view.expect_seq};
  assign in_win   = !diff[SEQ_BITS] && (diff < (SEQ_BITS + 1)'(WINDOW));
  assign seq_hit  = view.bits[seq_r[SLOT_BITS-1:0]];
  assign exp_hit  = view.bits[view.expect_seq[SLOT_BITS-1:0]];
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE);

  // Command to the shared unit for the current step.
  always_comb begin
    cmd.ch   = ch_r;
    cmd.slot = seq_r[SLOT_BITS-1:0];
    cmd.op   = OP_NONE;
    unique case (state)
      S_EVAL: begin
        if (in_win) begin
          if (!ch_r) begin
            if (!seq_hit) begin
              cmd.op = OP_SET;
            end
          end else if (seq_r == view.expect_seq) begin
            cmd.op = OP_CLR_ADV;
          end else begin
            cmd.op = OP_SET;
          end
        end
      end
      S_ADV: begin
        if (exp_hit) begin
          cmd.op = OP_CLR_ADV;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            ch_r  <= s_tuser[0];
            seq_r <= SEQ_BITS'(s_tdata[SEQ_FIELD_W-1:0]);
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          deliver_r <= 1'b0;
          state     <= S_DONE;
          if (!in_win) begin
            status_r <= ST_OUTSIDE;
          end else if (!ch_r) begin
            if (seq_hit) begin
              status_r <= ST_DUP;
            end else begin
              status_r  <= ST_DELIV;
              deliver_r <= 1'b1;
              state     <= S_ADV;
            end
          end else if (seq_r == view.expect_seq) begin
            status_r  <= ST_DELIV;
            deliver_r <= 1'b1;
          end else begin
            status_r <= ST_HELD;
          end
        end
        S_ADV: begin
          if (!exp_hit) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {4'b0, ch_r & exp_hit, view.bits,
                         SEQ_FIELD_W'(view.expect_seq), deliver_r, status_r};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // The deliver flag agrees with the delivered status.
  a_deliver_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2] == (m_tdata[1:0] == ST_DELIV)))
    else $error("deliver flag disagrees with status");

  // Only the reliable channel walks the bitmap.
  a_adv_reliable: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADV) |-> !ch_r)
    else $error("advance walk on ordered channel");

  // An accepted header is evaluated in the next cycle.
  a_accept_eval: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_EVAL))
    else $error("accepted header not evaluated");

  // A result is never overwritten while it waits.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready && state == S_DONE) |=> (state == S_DONE))
    else $error("pending result overwritten");
`endif

endmodule

/* hdl/rwt_state.sv */
module rwt_state (
  input  logic              clk,
  input  logic              rst,
  input  rwt_pkg::rwt_cmd_t cmd,
  output rwt_pkg::rwt_view_t view
);
  import rwt_pkg::*;

  logic [SEQ_BITS-1:0] expect_seq [2];
  logic [BMP_BITS-1:0] window_bits [2];
  logic [SLOT_BITS-1:0] cur_slot;

  assign cur_slot = expect_seq[cmd.ch][SLOT_BITS-1:0];

  // Selected channel state, read by the sequencer.
  assign view.expect_seq = expect_seq[cmd.ch];
  assign view.bits       = window_bits[cmd.ch];

  // Shared update unit: set one bit, or clear the slot of the next expected sequence
  // and step it on by one.
  always_ff @(posedge clk) begin
    if (rst) begin
      expect_seq[0]  <= '0;
      expect_seq[1]  <= '0;
      window_bits[0] <= '0;
      window_bits[1] <= '0;
    end else begin
      unique case (cmd.op)
        OP_SET: begin
          window_bits[cmd.ch][cmd.slot] <= 1'b1;
        end
        OP_CLR_ADV: begin
          window_bits[cmd.ch][cur_slot] <= 1'b0;
          expect_seq[cmd.ch]            <= expect_seq[cmd.ch] + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* dv/receive_ack_window_checker.sv */
`timescale 1ns / 1ps

// Channel codes shared by the checker and the stimulus.
package ack_window_tb_pkg;

  typedef enum logic {
    CH_RELIABLE = 1'b0,
    CH_ORDERED  = 1'b1
  } chan_t;

endpackage

module receive_ack_window_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [rwt_pkg::IN_DATA_W-1:0]  s_tdata,  // [15:0] seq_num
  input  logic [0:0]                     s_tuser,  // [0] chan_sel
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  // [1:0] status, [2] deliver, [18:3] next_expected, [82:19] ack_bitmap,
  // [83] replay_ready, [87:84] zero
  input  logic [rwt_pkg::OUT_DATA_W-1:0] m_tdata,
  output int                             fail_count,
  output int                             pending_results
);

  import rwt_pkg::*;
  import ack_window_tb_pkg::*;

  // Layout of one result transfer, highest field first.
  typedef struct packed {
    logic [3:0]          pad;
    logic                replay_ready;
    logic [BMP_BITS-1:0] ack_bitmap;
    logic [15:0]         next_expected;
    logic                deliver;
    rwt_status_t         status;
  } ack_word_t;

  // Own copy of the per-channel window state.
  logic [SEQ_BITS-1:0] next_seq [2];
  logic [BMP_BITS-1:0] win_bits [2];

  ack_word_t pending_acks [$];
  int        errors = 0;

  // Applies one header to the window state and returns the acknowledgement it should produce.
  function automatic ack_word_t track_header(input chan_t ch, input logic [15:0] seq);
    ack_word_t            res;
    int unsigned          lo;
    int unsigned          hi;
    logic [SLOT_BITS-1:0] slot;
    int                   n;
    res        = '0;
    res.status = ST_OUTSIDE;
    lo         = next_seq[ch];
    hi         = lo + WINDOW - 1;
    slot       = seq[SLOT_BITS-1:0];
    // The window is compared as plain integers, so it never wraps past the top.
    if (seq >= lo && seq <= hi) begin
      if (ch == CH_RELIABLE) begin
        if (win_bits[0][slot]) begin
          res.status = ST_DUP;
        end else begin
          win_bits[0][slot] = 1'b1;
          // Move past every consecutive received slot, clearing each one.
          for (n = 0; n < WINDOW; n++) begin
            if (!win_bits[0][next_seq[0][SLOT_BITS-1:0]]) break;
            win_bits[0][next_seq[0][SLOT_BITS-1:0]] = 1'b0;
            next_seq[0] = next_seq[0] + 1'b1;
          end
          res.status  = ST_DELIV;
          res.deliver = 1'b1;
        end
      end else if (seq == next_seq[1]) begin
        win_bits[1][slot] = 1'b0;
        next_seq[1]       = next_seq[1] + 1'b1;
        res.status        = ST_DELIV;
        res.deliver       = 1'b1;
      end else begin
        win_bits[1][slot] = 1'b1;
        res.status        = ST_HELD;
      end
    end
    if (ch == CH_ORDERED) begin
      res.replay_ready = win_bits[1][next_seq[1][SLOT_BITS-1:0]];
    end
    res.next_expected = next_seq[ch][15:0];
    res.ack_bitmap    = win_bits[ch];
    return res;
  endfunction

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      errors++;
    end
  endtask

  // Compare each result transfer with the oldest expectation, then predict new headers.
  always @(posedge clk) begin
    ack_word_t want;
    ack_word_t got;
    if (rst) begin
      next_seq[0] = '0;
      next_seq[1] = '0;
      win_bits[0] = '0;
      win_bits[1] = '0;
      pending_acks.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = ack_word_t'(m_tdata);
        if (pending_acks.size() == 0) begin
          $display("%0t ns: result with nothing expected, expected none, actual 0x%0h",
                   $time, m_tdata);
          errors++;
        end else begin
          want = pending_acks.pop_front();
          check_field("status", want.status, got.status);
          check_field("deliver", want.deliver, got.deliver);
          check_field("next_expected", want.next_expected, got.next_expected);
          check_field("ack_bitmap", want.ack_bitmap, got.ack_bitmap);
          check_field("replay_ready", want.replay_ready, got.replay_ready);
          check_field("padding", want.pad, got.pad);
        end
      end
      if (s_tvalid && s_tready) begin
        pending_acks.push_back(track_header(chan_t'(s_tuser[0]), s_tdata[15:0]));
      end
    end
    fail_count      <= errors;
    pending_results <= pending_acks.size();
  end

endmodule

/* dv/receive_ack_window_tracker_tb.sv */
`timescale 1ns / 1ps

module receive_ack_window_tracker_tb;

  import rwt_pkg::*;
  import ack_window_tb_pkg::*;

  localparam int          PHASE_ITEMS   = 500;
  localparam int          LONG_HOLD     = 300;
  localparam int          DRAIN_LIMIT   = 5000;
  localparam int          SETTLE_CYCLES = 80;

  logic                  clk;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic [0:0]            s_tuser  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  int                    fail_count;
  int                    pending_results;

  int          src_idle_pct  = 6;
  int          sink_idle_pct = 77;
  int          hold_cycles   = 0;
  logic        hold_taken    = 1'b0;
  int          headers_sent  = 0;
  logic [15:0] rel_next      = '0;
  logic [15:0] ord_next      = '0;

  receive_ack_window_tracker i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  receive_ack_window_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Result side: random stalls, or one long hold-off when asked for.
  initial begin
    @(posedge clk);
    forever begin
      if (hold_cycles > 0 && !hold_taken) begin
        hold_taken = 1'b1;
        m_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
        @(posedge clk);
      end
    end
  end

  // Offers one header, with random gaps first, and waits for its transfer.
  task automatic send_header(input chan_t ch, input logic [15:0] seq);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= ch;
    s_tdata  <= seq;
    do @(posedge clk); while (!s_tready);
    headers_sent++;
    if (ch == CH_ORDERED && seq == ord_next) ord_next = ord_next + 1'b1;
  endtask

  // A run of consecutive reliable sequences in shuffled order, with some repeats.
  task automatic reliable_burst();
    int          offs [64];
    int          k;
    int          room;
    int          i;
    int          j;
    int          tmp;
    logic [15:0] base;
    base = rel_next;
    room = 65536 - int'(base);
    k    = $urandom_range(1, 64);
    if (k > room) k = room;
    for (i = 0; i < k; i++) offs[i] = i;
    for (i = k - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      tmp     = offs[i];
      offs[i] = offs[j];
      offs[j] = tmp;
    end
    for (i = 0; i < k; i++) begin
      send_header(CH_RELIABLE, base + 16'(offs[i]));
      if ($urandom_range(9) == 0) begin
        send_header(CH_RELIABLE, base + 16'(offs[$urandom_range(0, i)]));
      end
    end
    rel_next = base + 16'(k);
  endtask

  // Mostly in-order ordered traffic, with holds close ahead, edge values and stale repeats.
  task automatic ordered_burst();
    int          k;
    int          pick;
    logic [15:0] seq;
    k = $urandom_range(1, 16);
    repeat (k) begin
      pick = $urandom_range(0, 19);
      if (pick < 11) begin
        seq = ord_next;
      end else if (pick < 15) begin
        seq = ord_next + 16'($urandom_range(1, 3));
      end else if (pick < 17) begin
        seq = ord_next + 16'($urandom_range(4, 63));
      end else if (pick == 17) begin
        seq = ord_next + 16'd64;
      end else begin
        seq = ord_next - 16'($urandom_range(1, 8));
      end
      send_header(CH_ORDERED, seq);
    end
  endtask

  // Noise: any value on the ordered channel, values outside the window on the reliable one.
  task automatic noise_header();
    if ($urandom_range(1)) begin
      send_header(CH_ORDERED, 16'($urandom_range(0, 65535)));
    end else if ($urandom_range(1)) begin
      send_header(CH_RELIABLE, rel_next + 16'd64 + 16'($urandom_range(0, 999)));
    end else begin
      send_header(CH_RELIABLE, rel_next - 16'd1 - 16'($urandom_range(0, 999)));
    end
  endtask

  task automatic random_phase(input int n);
    int start;
    int pick;
    start = headers_sent;
    while (headers_sent - start < n) begin
      pick = $urandom_range(0, 19);
      if (pick < 9) begin
        reliable_burst();
      end else if (pick < 17) begin
        ordered_burst();
      end else begin
        noise_header();
      end
    end
  endtask

  initial begin
    int waited;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reliable channel: first delivery, stale repeat, window edges, duplicate, no wrap,
    // then a gap filled from the top down that advances over several slots.
    send_header(CH_RELIABLE, 16'd0);
    send_header(CH_RELIABLE, 16'd0);
    send_header(CH_RELIABLE, 16'd65);
    send_header(CH_RELIABLE, 16'd64);
    send_header(CH_RELIABLE, 16'd64);
    send_header(CH_RELIABLE, 16'hFFFF);
    send_header(CH_RELIABLE, 16'd3);
    send_header(CH_RELIABLE, 16'd2);
    send_header(CH_RELIABLE, 16'd1);
    send_header(CH_RELIABLE, 16'h8000);
    rel_next = 16'd4;

    // Ordered channel: hold, repeated hold, edges, delivery with a replay waiting.
    send_header(CH_ORDERED, 16'd1);
    send_header(CH_ORDERED, 16'd1);
    send_header(CH_ORDERED, 16'd64);
    send_header(CH_ORDERED, 16'd63);
    send_header(CH_ORDERED, 16'd0);
    send_header(CH_ORDERED, 16'd1);
    send_header(CH_ORDERED, 16'd0);
    send_header(CH_ORDERED, 16'hFFFF);

    random_phase(PHASE_ITEMS);
    src_idle_pct  = 77;
    sink_idle_pct = 6;
    random_phase(PHASE_ITEMS);
    src_idle_pct  = 0;
    sink_idle_pct = 0;

    // Long hold-off on the result side while headers keep coming.
    hold_cycles = LONG_HOLD;
    random_phase(PHASE_ITEMS);
    s_tvalid <= 1'b0;

    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending_results != 0 && waited < DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d headers over both channels: window edges, duplicates, holds and replays,",
             headers_sent);
    $display("stalls on both sides and a long result hold-off with the input backed up.");
    if (fail_count == 0 && pending_results == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/rwt_pkg.sv
hdl/rwt_state.sv
hdl/receive_ack_window_tracker.sv
dv/receive_ack_window_checker.sv
dv/receive_ack_window_tracker_tb.sv
